// ===== hw/rtl/pfa_pkg.sv =====
package pfa_pkg;

  localparam int OP_W       = 2;
  localparam int SAMPLE_W   = 16;
  localparam int WORD_W     = 32;
  localparam int NUM_W      = 7;
  localparam int TOTAL_W    = 48;
  localparam int ADDR_W     = 12;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef struct packed {
    logic [OP_W-1:0]            kind;
    logic                       hit;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] sample;
    logic [NUM_W-1:0]           num;
  } cmd_t;

endpackage

// ===== hw/rtl/pfa_front.sv =====
module pfa_front
  import pfa_pkg::*;
#(
  parameter int NUM_BINS = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_op,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [WORD_W-1:0]          in_ref_phase,
  input  logic [WORD_W-1:0]          in_time_offset,
  input  logic [WORD_W-1:0]          in_spin_freq,
  input  logic [NUM_W-1:0]           in_read_bin,
  input  logic                       hold,
  input  logic [QCNT_W-1:0]          q_cnt,
  output logic                       push,
  output cmd_t                       push_cmd
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int XW = ((AW > NUM_W) ? AW : NUM_W) + 1;
  localparam int SW = WORD_W + AW + 1;

  logic                       v1_r;
  logic                       v2_r;
  logic [OP_W-1:0]            op1_r;
  logic signed [SAMPLE_W-1:0] samp1_r;
  logic [WORD_W-1:0]          phase1_r;
  logic [NUM_W-1:0]           rb1_r;
  logic [2*WORD_W-1:0]        prod1_r;
  logic [OP_W-1:0]            kind2_r;
  logic signed [SAMPLE_W-1:0] samp2_r;
  logic [NUM_W-1:0]           rb2_r;
  logic [WORD_W-1:0]          frac2_r;
  logic [OP_W-1:0]            kind_nxt;
  logic [SW-1:0]              scaled;
  logic [AW:0]                bin_raw;
  logic [AW-1:0]              bin_sel;
  logic                       rb_hit;
  logic [QCNT_W:0]            inflight;
  logic                       accept;

  assign inflight = (QCNT_W+1)'(q_cnt) + (QCNT_W+1)'(v1_r) + (QCNT_W+1)'(v2_r);
  assign in_ready = !hold && (inflight < (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (op1_r)
      OP_ACC:   kind_nxt = OP_ACC;
      OP_CLEAR: kind_nxt = OP_CLEAR;
      default:  kind_nxt = OP_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op1_r    <= in_op;
      samp1_r  <= in_sample;
      phase1_r <= in_ref_phase;
      rb1_r    <= in_read_bin;
      prod1_r  <= {{WORD_W{1'b0}}, in_time_offset} * {{WORD_W{1'b0}}, in_spin_freq};
    end
    if (v1_r) begin
      kind2_r <= kind_nxt;
      samp2_r <= samp1_r;
      rb2_r   <= rb1_r;
      frac2_r <= prod1_r[WORD_W+13:14] + phase1_r;
    end
  end

  assign scaled  = SW'(frac2_r) * SW'(NUM_BINS) + (SW'(1) << (WORD_W - 1));
  assign bin_raw = scaled[SW-1:WORD_W];
  assign bin_sel = (bin_raw == (AW+1)'(NUM_BINS)) ? '0 : bin_raw[AW-1:0];
  assign rb_hit  = XW'(rb2_r) < XW'(NUM_BINS);

  always_comb begin
    push            = v2_r;
    push_cmd.kind   = kind2_r;
    push_cmd.sample = samp2_r;
    if (kind2_r == OP_ACC) begin
      push_cmd.hit  = 1'b1;
      push_cmd.addr = ADDR_W'(bin_sel);
      push_cmd.num  = NUM_W'(bin_sel);
    end else begin
      push_cmd.hit  = rb_hit;
      push_cmd.addr = ADDR_W'(rb2_r);
      push_cmd.num  = rb2_r;
    end
  end

endmodule

// ===== hw/rtl/pfa_queue.sv =====
module pfa_queue
  import pfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cmd_t              push_cmd,
  input  logic              pop,
  output logic              q_valid,
  output cmd_t              q_head,
  output logic [QCNT_W-1:0] q_cnt
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign q_valid = (cnt_r != '0);
  assign q_head  = slot_r[rd_ptr_r];
  assign q_cnt   = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/pfa_back.sv =====
module pfa_back
  import pfa_pkg::*;
#(
  parameter int NUM_BINS = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  cmd_t                      q_head,
  output logic                      pop,
  output logic                      clr_busy,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [NUM_W-1:0]          out_bin_number,
  output logic signed [TOTAL_W-1:0] out_bin_total,
  output logic                      out_saturated
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic [TOTAL_W-1:0] mem [NUM_BINS];

  logic               clr_busy_r;
  logic [AW-1:0]      clr_idx_r;
  logic               s1_valid_r;
  cmd_t               s1_cmd_r;
  logic [TOTAL_W-1:0] rd_r;
  logic               wb_valid_r;
  logic [AW-1:0]      wb_addr_r;
  logic [TOTAL_W-1:0] wb_data_r;
  logic               out_valid_r;
  logic [NUM_W-1:0]   out_num_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_sat_r;

  logic               adv;
  logic [AW-1:0]      s1_addr;
  logic [TOTAL_W-1:0] cur;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] acc_total;
  logic               acc_sat;
  logic               do_write;
  logic [TOTAL_W-1:0] wr_data;
  logic [TOTAL_W-1:0] res_total;
  logic               res_sat;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [TOTAL_W-1:0] mem_wdata;

  assign adv      = !out_valid_r || out_ready;
  assign pop      = adv && q_valid && !clr_busy_r;
  assign clr_busy = clr_busy_r;
  assign s1_addr  = s1_cmd_r.addr[AW-1:0];

  assign cur = (wb_valid_r && (wb_addr_r == s1_addr)) ? wb_data_r : rd_r;
  assign sum = {cur[TOTAL_W-1], cur}
             + {{(TOTAL_W+1-SAMPLE_W){s1_cmd_r.sample[SAMPLE_W-1]}}, s1_cmd_r.sample};

  always_comb begin
    acc_sat   = (sum[TOTAL_W] != sum[TOTAL_W-1]);
    acc_total = sum[TOTAL_W-1:0];
    if (acc_sat) begin
      acc_total = sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    end
  end

  always_comb begin
    do_write  = 1'b0;
    wr_data   = '0;
    res_total = '0;
    res_sat   = 1'b0;
    case (s1_cmd_r.kind)
      OP_ACC: begin
        do_write  = 1'b1;
        wr_data   = acc_total;
        res_total = acc_total;
        res_sat   = acc_sat;
      end
      OP_CLEAR: begin
        do_write  = s1_cmd_r.hit;
        res_total = s1_cmd_r.hit ? cur : '0;
      end
      default: begin
        res_total = s1_cmd_r.hit ? cur : '0;
      end
    endcase
  end

  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && s1_valid_r && do_write;
      mem_waddr = s1_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_r <= mem[q_head.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(NUM_BINS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid_r  <= pop;
        wb_valid_r  <= s1_valid_r && do_write;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cmd_r <= q_head;
    end
    if (adv && s1_valid_r) begin
      wb_addr_r   <= s1_addr;
      wb_data_r   <= wr_data;
      out_num_r   <= s1_cmd_r.num;
      out_total_r <= res_total;
      out_sat_r   <= res_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_number = out_num_r;
  assign out_bin_total  = out_total_r;
  assign out_saturated  = out_sat_r;

endmodule

// ===== hw/rtl/phase_fold_profile_accumulator.sv =====
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   op, sample, ref_phase, time_offset,
//                                            spin_freq, read_bin
// out_      output     out_valid / out_ready bin_number, bin_total, saturated
//
// One item per cycle while out_ready is high and the reset sweep is done; a transfer
// in is registered through multiply, phase add, bin scale into the queue, bin memory
// read and update before out_valid. Throughput is set by the single read and single
// write port of the bin memory; back-to-back updates of one bin are forwarded from
// the last write. After reset the block sweeps the bin memory to zero, one bin per
// cycle, and holds in_ready low until the sweep is done. A stall on out_ready backs
// up the 4-entry command queue; in_ready drops at 4 queued plus in-flight items.
module phase_fold_profile_accumulator
  import pfa_pkg::*;
#(
  parameter int NUM_BINS = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_op,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [WORD_W-1:0]          in_ref_phase,
  input  logic [WORD_W-1:0]          in_time_offset,
  input  logic [WORD_W-1:0]          in_spin_freq,
  input  logic [NUM_W-1:0]           in_read_bin,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [NUM_W-1:0]           out_bin_number,
  output logic signed [TOTAL_W-1:0]  out_bin_total,
  output logic                       out_saturated
);

  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  logic              q_valid;
  cmd_t              q_head;
  logic [QCNT_W-1:0] q_cnt;
  logic              clr_busy;

  pfa_front #(
    .NUM_BINS(NUM_BINS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_sample      (in_sample),
    .in_ref_phase   (in_ref_phase),
    .in_time_offset (in_time_offset),
    .in_spin_freq   (in_spin_freq),
    .in_read_bin    (in_read_bin),
    .hold           (clr_busy),
    .q_cnt          (q_cnt),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  pfa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_cnt    (q_cnt)
  );

  pfa_back #(
    .NUM_BINS(NUM_BINS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .pop            (pop),
    .clr_busy       (clr_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bin_number (out_bin_number),
    .out_bin_total  (out_bin_total),
    .out_saturated  (out_saturated)
  );

endmodule

// ===== tb/tb_phase_fold_profile_accumulator.sv =====
module tb_phase_fold_profile_accumulator
  import pfa_pkg::*;
();

  localparam int NUM_BINS = 128;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 255;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam longint TOTAL_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint TOTAL_LO = -TOTAL_HI - 1;

  typedef struct packed {
    logic [NUM_W-1:0]           bin_number;
    logic signed [TOTAL_W-1:0]  bin_total;
    logic                       saturated;
  } fold_result_t;

  class fold_profile_tracker;
    logic signed [TOTAL_W-1:0] bin_totals [NUM_BINS];
    fold_result_t expected [$];
    int failures, n_checked, n_acc, n_read, n_clear, n_spare, n_wrap, n_sat;

    function new();
      foreach (bin_totals[i]) bin_totals[i] = '0;
      failures = 0;
      n_checked = 0;
      n_acc = 0;
      n_read = 0;
      n_clear = 0;
      n_spare = 0;
      n_wrap = 0;
      n_sat = 0;
    endfunction

    // Fractional turns contributed by time offset times spin frequency, Q0.32.
    function logic [WORD_W-1:0] fold_term(logic [WORD_W-1:0] toff, logic [WORD_W-1:0] freq);
      logic [63:0] product;
      product = {32'b0, toff} * {32'b0, freq};
      return product[45:14];
    endfunction

    function void note_transfer(logic [OP_W-1:0] op, logic signed [SAMPLE_W-1:0] value,
                                logic [WORD_W-1:0] phase0, logic [WORD_W-1:0] toff,
                                logic [WORD_W-1:0] freq, logic [NUM_W-1:0] rb);
      fold_result_t res;
      logic [WORD_W-1:0] frac;
      logic [63:0] scaled;
      int unsigned idx;
      longint total;
      res.saturated = 1'b0;
      if (op == OP_ACC) begin
        n_acc++;
        frac = fold_term(toff, freq) + phase0;
        scaled = {32'b0, frac} * 64'(NUM_BINS) + 64'h8000_0000;
        idx = scaled[63:32];
        if (idx >= NUM_BINS) begin
          idx = 0;
          n_wrap++;
        end
        total = longint'(bin_totals[idx]) + longint'(value);
        if (total > TOTAL_HI) begin
          total = TOTAL_HI;
          res.saturated = 1'b1;
        end else if (total < TOTAL_LO) begin
          total = TOTAL_LO;
          res.saturated = 1'b1;
        end
        if (res.saturated) n_sat++;
        bin_totals[idx] = total[TOTAL_W-1:0];
        res.bin_number = idx[NUM_W-1:0];
        res.bin_total = total[TOTAL_W-1:0];
      end else begin
        if (op == OP_CLEAR) n_clear++;
        else if (op == OP_READ) n_read++;
        else n_spare++;
        res.bin_number = rb;
        if (int'(rb) >= NUM_BINS) begin
          res.bin_total = '0;
        end else begin
          res.bin_total = bin_totals[rb];
          if (op == OP_CLEAR) bin_totals[rb] = '0;
        end
      end
      expected.push_back(res);
    endfunction

    function void check_result(logic [NUM_W-1:0] bn, logic signed [TOTAL_W-1:0] tot,
                               logic sat);
      fold_result_t want;
      n_checked++;
      if (expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result transfer: bin %0d total %0d saturated %0b", bn, tot, sat);
        return;
      end
      want = expected.pop_front();
      if (bn !== want.bin_number || tot !== want.bin_total || sat !== want.saturated) begin
        failures++;
        if (failures <= 10)
          $display("mismatch at result %0d: bin %0d/%0d total %0d/%0d saturated %0b/%0b",
                   n_checked, want.bin_number, bn, want.bin_total, tot, want.saturated, sat);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_op = OP_ACC;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [WORD_W-1:0] in_ref_phase = '0;
  logic [WORD_W-1:0] in_time_offset = '0;
  logic [WORD_W-1:0] in_spin_freq = '0;
  logic [NUM_W-1:0] in_read_bin = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [NUM_W-1:0] out_bin_number;
  logic signed [TOTAL_W-1:0] out_bin_total;
  logic out_saturated;

  fold_profile_tracker sb;
  int idle_mode = 0;
  int cycle_count = 0;

  phase_fold_profile_accumulator #(
    .NUM_BINS(NUM_BINS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_sample(in_sample),
    .in_ref_phase(in_ref_phase),
    .in_time_offset(in_time_offset),
    .in_spin_freq(in_spin_freq),
    .in_read_bin(in_read_bin),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bin_number(out_bin_number),
    .out_bin_total(out_bin_total),
    .out_saturated(out_saturated)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == 0) return 0;
    if (idle_mode == 1) return (r < 80) ? 0 : $urandom_range(1, 3);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [SAMPLE_W-1:0] value,
                           input logic [WORD_W-1:0] phase0, input logic [WORD_W-1:0] toff,
                           input logic [WORD_W-1:0] freq, input logic [NUM_W-1:0] rb);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_sample <= value;
    in_ref_phase <= phase0;
    in_time_offset <= toff;
    in_spin_freq <= freq;
    in_read_bin <= rb;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(op, value, phase0, toff, freq, rb);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_bin_number, out_bin_total, out_saturated);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [OP_W-1:0] op;
    logic signed [SAMPLE_W-1:0] value;
    logic [WORD_W-1:0] phase0, toff, freq, frac;
    logic [NUM_W-1:0] rb;
    int hot_set [4];
    int hb, r, p, k, fails;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // back-to-back transfers so same-bin updates hit the forwarding path
    idle_mode = 0;
    send_item(OP_ACC, 16'sh7FFF, 32'h0000_0000, 32'h0, 32'h0, 7'($urandom));
    send_item(OP_ACC, 16'sh7FFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 7'($urandom));
    send_item(OP_ACC, 16'sh8000, 32'h00FF_FFFF, 32'h0, 32'h0, 7'($urandom));
    send_item(OP_ACC, 16'sh8000, 32'h0100_0000, 32'h0, 32'h0, 7'($urandom));
    send_item(OP_ACC, 16'sh0001, 32'hFEFF_FFFF, 32'h0, 32'h0, 7'($urandom));
    send_item(OP_ACC, -16'sd1, 32'hFF00_0000, 32'h0, 32'h0, 7'($urandom));
    send_item(OP_ACC, 16'sh1234, 32'h0, 32'h0100_0000, 32'h0040_0000, 7'($urandom));
    send_item(OP_ACC, -16'sd2, 32'h0, 32'h0080_0000, 32'h0040_0000, 7'($urandom));
    send_item(OP_ACC, 16'sh7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'($urandom));
    repeat (3) send_item(OP_ACC, 16'sh7FFF, 32'h0A00_0000, 32'h0, 32'h0, 7'($urandom));
    send_item(OP_READ, 16'($urandom), $urandom, $urandom, $urandom, 7'd0);
    send_item(OP_READ, 16'($urandom), $urandom, $urandom, $urandom, 7'd127);
    send_item(OP_SPARE, 16'($urandom), $urandom, $urandom, $urandom, 7'd64);
    send_item(OP_CLEAR, 16'($urandom), $urandom, $urandom, $urandom, 7'd5);
    send_item(OP_READ, 16'($urandom), $urandom, $urandom, $urandom, 7'd5);
    send_item(OP_CLEAR, 16'($urandom), $urandom, $urandom, $urandom, 7'd0);
    send_item(OP_ACC, 16'sh0055, 32'h0, 32'h0, 32'h0, 7'($urandom));
    send_item(OP_READ, 16'($urandom), $urandom, $urandom, $urandom, 7'd0);
    send_item(OP_READ, 16'($urandom), $urandom, $urandom, $urandom, 7'd1);
    send_item(OP_CLEAR, 16'($urandom), $urandom, $urandom, $urandom, 7'd127);
    send_item(OP_READ, 16'($urandom), $urandom, $urandom, $urandom, 7'd127);

    for (p = 0; p < PHASES; p++) begin
      idle_mode = p % 3;
      hot_set[0] = (p % 2) ? NUM_BINS - 1 : 0;
      for (k = 1; k < 4; k++) hot_set[k] = $urandom_range(0, NUM_BINS - 1);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 62) op = OP_ACC;
        else if (r < 78) op = OP_READ;
        else if (r < 94) op = OP_CLEAR;
        else op = OP_SPARE;
        hb = hot_set[$urandom_range(0, 3)];
        r = $urandom_range(0, 99);
        if (r < 10) value = 16'sh7FFF;
        else if (r < 20) value = 16'sh8000;
        else value = 16'($urandom);
        toff = $urandom;
        freq = $urandom;
        phase0 = $urandom;
        // steer the fold onto a hot bin, anywhere inside its rounding window
        if (op == OP_ACC && $urandom_range(0, 99) < 65) begin
          frac = (32'(hb) << 25) + 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
          phase0 = frac - sb.fold_term(toff, freq);
        end
        rb = ($urandom_range(0, 99) < 75) ? 7'(hb) : 7'($urandom_range(0, NUM_BINS - 1));
        send_item(op, value, phase0, toff, freq, rb);
      end
    end
    in_valid <= 1'b0;
    idle_mode = 0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    fails = sb.failures + sb.expected.size();
    if (sb.expected.size() != 0)
      $display("%0d expected results never arrived", sb.expected.size());
    $display("Folded %0d samples (%0d wrapped to bin 0, %0d saturated); %0d reads, %0d clears,",
             sb.n_acc, sb.n_wrap, sb.n_sat, sb.n_read, sb.n_clear);
    $display("%0d spare-code reads; %0d results checked, %0d failures.",
             sb.n_spare, sb.n_checked, fails);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
